// ===== rtl/icba_pkg.sv =====
// shared types and constants for the idle cpu bitmap allocator
// no dependencies; used by the interfaces and every rtl module
`default_nettype none

package icba_pkg;

    localparam int CMD_W      = 3;
    localparam int IDX_W      = 6;
    localparam int NODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam int NUM_PROCESSORS_DEF = 64;
    localparam int NUM_NODES_DEF      = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_MARK_IDLE    = 3'd0,
        CMD_TAKE_ANY     = 3'd1,
        CMD_TAKE_IN_NODE = 3'd2,
        CMD_TAKE_ALL     = 3'd3,
        CMD_UNIDLE       = 3'd4
    } t_command;

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        DP_NOP,
        DP_MARK,
        DP_TAKE,
        DP_UNIDLE,
        DP_NONE_FOUND,
        DP_ALL_STEP
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   use_node;
    } t_dp_cmd;

    typedef struct packed {
        logic out_space;
        logic any_idle;
        logic rest_empty;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/icba_cmd_if.sv =====
// command channel: one beat per command
// depends on icba_pkg for field widths
`default_nettype none

interface icba_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [icba_pkg::CMD_W-1:0]   command;
    logic [icba_pkg::IDX_W-1:0]   cpu_index;
    logic [icba_pkg::NODE_W-1:0]  node_id;

    modport source (output valid, command, cpu_index, node_id, input ready);
    modport sink   (input valid, command, cpu_index, node_id, output ready);
endinterface

`default_nettype wire

// ===== rtl/icba_rsp_if.sv =====
// result channel: one beat per result
// depends on icba_pkg for field widths
`default_nettype none

interface icba_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [icba_pkg::IDX_W-1:0] taken_index;
    logic                       last;

    modport source (output valid, found, taken_index, last, input ready);
    modport sink   (input valid, found, taken_index, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/icba_cfg_if.sv =====
// configuration write channel: register index and write data
// depends on icba_pkg for field widths
`default_nettype none

interface icba_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [icba_pkg::CFG_IDX_W-1:0]  index;
    logic [icba_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/icba_ctrl.sv =====
// controller: command decode and the take_all sequencing
// depends on icba_pkg for command codes and datapath command/status types
`default_nettype none

module icba_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic [icba_pkg::CMD_W-1:0] i_command,
    input  wire icba_pkg::t_dp_status       i_status,
    output logic                            o_ready,
    output icba_pkg::t_dp_cmd               o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_ALL  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_needs_rsp;

    always_comb begin
        case (i_command) inside
            icba_pkg::CMD_TAKE_ANY, icba_pkg::CMD_TAKE_IN_NODE,
            icba_pkg::CMD_TAKE_ALL, icba_pkg::CMD_UNIDLE: w_needs_rsp = 1'b1;
            default:                                      w_needs_rsp = 1'b0;
        endcase
    end

    always_comb begin
        n_state        = r_state;
        o_ready        = 1'b0;
        o_cmd.op       = icba_pkg::DP_NOP;
        o_cmd.use_node = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = i_status.out_space || !w_needs_rsp;
                if (i_valid && o_ready) begin
                    unique case (i_command)
                        icba_pkg::CMD_MARK_IDLE: o_cmd.op = icba_pkg::DP_MARK;
                        icba_pkg::CMD_TAKE_ANY:  o_cmd.op = icba_pkg::DP_TAKE;
                        icba_pkg::CMD_TAKE_IN_NODE: begin
                            o_cmd.op       = icba_pkg::DP_TAKE;
                            o_cmd.use_node = 1'b1;
                        end
                        icba_pkg::CMD_TAKE_ALL: begin
                            if (i_status.any_idle) begin
                                n_state = ST_ALL;
                            end else begin
                                o_cmd.op = icba_pkg::DP_NONE_FOUND;
                            end
                        end
                        icba_pkg::CMD_UNIDLE: o_cmd.op = icba_pkg::DP_UNIDLE;
                        default:              o_cmd.op = icba_pkg::DP_NOP;
                    endcase
                end
            end
            ST_ALL: begin
                if (i_status.out_space) begin
                    o_cmd.op = icba_pkg::DP_ALL_STEP;
                    if (i_status.rest_empty) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/icba_dp.sv =====
// datapath: idle bitmap, node masks, lowest-set-bit encoder, result register
// depends on icba_pkg for widths and datapath command/status types
`default_nettype none

module icba_dp #(
    parameter int NUM_PROCESSORS = icba_pkg::NUM_PROCESSORS_DEF,
    parameter int NUM_NODES      = icba_pkg::NUM_NODES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire icba_pkg::t_dp_cmd               i_cmd,
    input  wire logic [icba_pkg::IDX_W-1:0]      i_cpu_index,
    input  wire logic [icba_pkg::NODE_W-1:0]     i_node_id,
    input  wire logic                            i_cfg_write,
    input  wire logic [icba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [icba_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic                                 o_found,
    output logic [icba_pkg::IDX_W-1:0]           o_taken_index,
    output logic                                 o_last,
    output icba_pkg::t_dp_status                 o_status
);

    localparam int NP = NUM_PROCESSORS;

    logic [NP-1:0]              r_idle_bits;
    logic [NP-1:0]              n_idle_bits;
    logic [NP-1:0]              r_mask [NUM_NODES];
    logic                       r_out_valid;
    logic                       r_found;
    logic [icba_pkg::IDX_W-1:0] r_index;
    logic                       r_last;

    logic [NP-1:0]              w_sel_mask;
    logic [NP-1:0]              w_cand;
    logic [NP-1:0]              w_low;
    logic [icba_pkg::IDX_W-1:0] w_low_idx;
    logic [NP-1:0]              w_cpu_bit;
    logic                       w_cpu_ok;
    logic                       w_cpu_set;
    logic                       w_load;
    logic                       w_found;
    logic [icba_pkg::IDX_W-1:0] w_index;
    logic                       w_last;

    // node mask write
    for (genvar n = 0; n < NUM_NODES; n++) begin : g_mask
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mask[n] <= '0;
            end else if (i_cfg_write && (i_cfg_index == icba_pkg::CFG_IDX_W'(n))) begin
                r_mask[n] <= i_cfg_data[NP-1:0];
            end
        end
    end

    always_comb begin
        w_sel_mask = '0;
        for (int n = 0; n < NUM_NODES; n++) begin
            if (i_node_id == icba_pkg::NODE_W'(n)) begin
                w_sel_mask = r_mask[n];
            end
        end
    end

    // lowest set bit: isolate, then one-hot to binary
    assign w_cand = r_idle_bits & (i_cmd.use_node ? w_sel_mask : {NP{1'b1}});
    assign w_low  = w_cand & (~w_cand + NP'(1));

    always_comb begin
        w_low_idx = '0;
        for (int i = 0; i < NP; i++) begin
            if (w_low[i]) begin
                w_low_idx = w_low_idx | icba_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NP; i++) begin
            w_cpu_bit[i] = (i_cpu_index == icba_pkg::IDX_W'(i));
        end
    end

    assign w_cpu_ok  = {1'b0, i_cpu_index} < (icba_pkg::IDX_W + 1)'(NP);
    assign w_cpu_set = w_cpu_ok && ((r_idle_bits & w_cpu_bit) != '0);

    always_comb begin
        n_idle_bits = r_idle_bits;
        w_load      = 1'b0;
        w_found     = 1'b0;
        w_index     = '0;
        w_last      = 1'b1;
        case (i_cmd.op)
            icba_pkg::DP_MARK: begin
                if (w_cpu_ok) begin
                    n_idle_bits = r_idle_bits | w_cpu_bit;
                end
            end
            icba_pkg::DP_TAKE: begin
                w_load = 1'b1;
                if (w_cand != '0) begin
                    w_found     = 1'b1;
                    w_index     = w_low_idx;
                    n_idle_bits = r_idle_bits & ~w_low;
                end
            end
            icba_pkg::DP_UNIDLE: begin
                w_load = 1'b1;
                if (w_cpu_set) begin
                    w_found     = 1'b1;
                    w_index     = i_cpu_index;
                    n_idle_bits = r_idle_bits & ~w_cpu_bit;
                end
            end
            icba_pkg::DP_NONE_FOUND: w_load = 1'b1;
            icba_pkg::DP_ALL_STEP: begin
                w_load      = 1'b1;
                w_found     = 1'b1;
                w_index     = w_low_idx;
                w_last      = o_status.rest_empty;
                n_idle_bits = r_idle_bits & ~w_low;
            end
            default: n_idle_bits = r_idle_bits;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_bits <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idle_bits <= n_idle_bits;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_found <= w_found;
            r_index <= w_index;
            r_last  <= w_last;
        end
    end

    assign o_status.out_space  = !r_out_valid || i_out_ready;
    assign o_status.any_idle   = r_idle_bits != '0;
    assign o_status.rest_empty = (w_cand & ~w_low) == '0;

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_taken_index = r_index;
    assign o_last        = r_last;

endmodule

`default_nettype wire

// ===== rtl/idle_cpu_bitmap_allocator.sv =====
// idle cpu bitmap allocator: top level joining controller and datapath
// depends on icba_pkg, icba_cmd_if, icba_rsp_if, icba_cfg_if, icba_ctrl, icba_dp
//
// usage
// - i_cmd carries one command per beat: mark_idle, take_any, take_in_node,
//   take_all or unidle, with the cpu index and node id they need
// - o_rsp carries results: found, taken_index (zero when not found) and last
// - i_cfg writes the node masks, index 0..3 for nodes 0..3; always ready; the
//   user writes them only while the block has no command in flight, unchecked
// - mark_idle and unused codes give no result
// - take_any, take_in_node and unidle give one result, visible in the cycle
//   after the beat is accepted; one command per cycle while o_rsp drains
// - take_all with k idle cpus gives k results, one per cycle while o_rsp
//   drains, lowest index first; the next command is taken in the cycle after
//   the last result is loaded
// - one 64-bit lowest-set-bit encoder in the datapath serves the take
//   commands and every take_all step
// - reset clears the bitmap and the node masks; no clearing pass is needed
// - a stalled o_rsp holds its result; commands that need a result wait, a
//   mark_idle is still accepted
`default_nettype none

module idle_cpu_bitmap_allocator #(
    parameter int NUM_PROCESSORS = icba_pkg::NUM_PROCESSORS_DEF,
    parameter int NUM_NODES      = icba_pkg::NUM_NODES_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    icba_cmd_if.sink    i_cmd,
    icba_cfg_if.sink    i_cfg,
    icba_rsp_if.source  o_rsp
);

    icba_pkg::t_dp_cmd    w_dp_cmd;
    icba_pkg::t_dp_status w_dp_status;

    // configuration writes complete at once
    assign i_cfg.ready = 1'b1;

    icba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_cmd.valid),
        .i_command (i_cmd.command),
        .i_status  (w_dp_status),
        .o_ready   (i_cmd.ready),
        .o_cmd     (w_dp_cmd)
    );

    icba_dp #(
        .NUM_PROCESSORS (NUM_PROCESSORS),
        .NUM_NODES      (NUM_NODES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_dp_cmd),
        .i_cpu_index   (i_cmd.cpu_index),
        .i_node_id     (i_cmd.node_id),
        .i_cfg_write   (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_found       (o_rsp.found),
        .o_taken_index (o_rsp.taken_index),
        .o_last        (o_rsp.last),
        .o_status      (w_dp_status)
    );

`ifndef SYNTHESIS
    // a result is loaded only when the output register is free or draining
    a_load_has_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dp_cmd.op == icba_pkg::DP_TAKE || w_dp_cmd.op == icba_pkg::DP_UNIDLE ||
         w_dp_cmd.op == icba_pkg::DP_NONE_FOUND || w_dp_cmd.op == icba_pkg::DP_ALL_STEP)
        |-> w_dp_status.out_space)
        else $error("result loaded into a full output register");

    // while a take_all sequence is mid-way no new command is taken
    a_no_cmd_mid_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.last) |-> !i_cmd.ready)
        else $error("command accepted during a take_all sequence");

    // a not-found result is always final and carries index zero
    a_not_found_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.found) |-> (o_rsp.last && o_rsp.taken_index == '0))
        else $error("malformed not-found result");

    // a take_all step always follows from a nonempty bitmap
    a_step_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dp_cmd.op == icba_pkg::DP_ALL_STEP) |-> w_dp_status.any_idle)
        else $error("take_all step on an empty bitmap");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the idle cpu bitmap allocator
// depends on icba_pkg and the icba_cmd_if, icba_rsp_if, icba_cfg_if interfaces
// a built-in predictor tracks the idle map and node masks and checks each result beat
`timescale 1ns / 100ps

module tb;

    localparam int CMD_W     = icba_pkg::CMD_W;
    localparam int IDX_W     = icba_pkg::IDX_W;
    localparam int NODE_W    = icba_pkg::NODE_W;
    localparam int CFG_IDX_W = icba_pkg::CFG_IDX_W;

    // block size as instantiated (package defaults)
    localparam int NPROC  = icba_pkg::NUM_PROCESSORS_DEF;
    localparam int NNODES = icba_pkg::NUM_NODES_DEF;

    // register indexes of the node masks
    localparam logic [CFG_IDX_W-1:0] NODE_MASK_ZERO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] NODE_MASK_ONE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] NODE_MASK_TWO   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] NODE_MASK_THREE = 2'd3;

    // command codes the block must ignore
    localparam logic [CMD_W-1:0] CMD_RESERVED_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RESERVED_MID   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RESERVED_LAST  = 3'd7;

    localparam logic [63:0] PROC_MASK =
        (NPROC >= 64) ? {64{1'b1}} : ((64'd1 << NPROC) - 64'd1);

    localparam int LONG_HOLD_CYCLES = 300;  // receiver back-pressure stretch
    localparam int DRAIN_CYCLES     = 8;    // covers a trailing mark_idle or ignored code

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [IDX_W-1:0]  cpu_index;
        logic [NODE_W-1:0] node_id;
    } t_cpu_cmd;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] taken_index;
        logic             last;
    } t_alloc_result;

    logic i_clk;
    logic i_rst_n;

    icba_cmd_if cmd_bus ();
    icba_rsp_if rsp_bus ();
    icba_cfg_if cfg_bus ();

    idle_cpu_bitmap_allocator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .i_cfg   (cfg_bus),
        .o_rsp   (rsp_bus)
    );

    // commands waiting for the driver, results waiting for the dut
    t_cpu_cmd      pending_cmds[$];
    t_alloc_result expected_results[$];

    // predictor state: mirrors the idle bitmap and the node masks
    logic [63:0] idle_map;
    logic [63:0] node_masks [NNODES];

    int unsigned mismatches = 0;

    // driver bookkeeping
    logic        cmd_accepted = 1'b0;
    int unsigned gap_left     = 0;
    int unsigned burst_left   = 0;

    // receiver bookkeeping
    logic        long_hold_armed = 1'b0;
    int unsigned hold_count      = 0;
    int unsigned pattern_left    = 0;
    int unsigned stall_style     = 0;
    logic        rsp_toggle      = 1'b0;

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void queue_result(input logic found, input logic [IDX_W-1:0] idx,
                                         input logic last);
        t_alloc_result r;
        r.found          = found;
        r.taken_index    = idx;
        r.last           = last;
        expected_results = {expected_results, r};
    endfunction

    // applies one accepted command to the idle map and queues its result beats
    function automatic void predict_allocation(input t_cpu_cmd c);
        logic [63:0] cand;
        logic        hit;
        int          pick;
        hit  = 1'b0;
        pick = 0;
        case (c.command) inside
            icba_pkg::CMD_MARK_IDLE: begin
                if (int'(c.cpu_index) < NPROC)
                    idle_map[c.cpu_index] = 1'b1;
            end
            icba_pkg::CMD_TAKE_ANY, icba_pkg::CMD_TAKE_IN_NODE: begin
                cand = idle_map & PROC_MASK;
                // a node outside the configured range selects nothing
                if (c.command == icba_pkg::CMD_TAKE_IN_NODE)
                    cand &= (int'(c.node_id) < NNODES) ? node_masks[c.node_id] : 64'd0;
                for (int i = 63; i >= 0; i--) begin
                    if (cand[i]) begin
                        hit  = 1'b1;
                        pick = i;
                    end
                end
                if (hit) begin
                    idle_map[pick] = 1'b0;
                    queue_result(1'b1, IDX_W'(pick), 1'b1);
                end else begin
                    queue_result(1'b0, '0, 1'b1);
                end
            end
            icba_pkg::CMD_TAKE_ALL: begin
                cand = idle_map & PROC_MASK;
                if (cand == 64'd0) begin
                    queue_result(1'b0, '0, 1'b1);
                end else begin
                    // ascending order, last flag on the highest set bit
                    for (int i = 0; i < 64; i++) begin
                        if (cand[i])
                            queue_result(1'b1, IDX_W'(i), (cand >> (i + 1)) == 64'd0);
                    end
                    idle_map = '0;
                end
            end
            icba_pkg::CMD_UNIDLE: begin
                if (int'(c.cpu_index) < NPROC && idle_map[c.cpu_index]) begin
                    idle_map[c.cpu_index] = 1'b0;
                    queue_result(1'b1, c.cpu_index, 1'b1);
                end else begin
                    queue_result(1'b0, '0, 1'b1);
                end
            end
            default: ;  // reserved codes: no result, no state change
        endcase
    endfunction

    // ------------------------------------------------------------------
    // monitor: command and config beats feed the predictor, result beats are checked
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : beat_monitor
        t_alloc_result want;
        t_alloc_result got;
        t_cpu_cmd      seen;
        cmd_accepted <= i_rst_n && cmd_bus.valid && cmd_bus.ready;
        if (!i_rst_n) begin
            idle_map = '0;
            for (int n = 0; n < NNODES; n++)
                node_masks[n] = '0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                got.found       = rsp_bus.found;
                got.taken_index = rsp_bus.taken_index;
                got.last        = rsp_bus.last;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat expected none actual %s",
                             $time, $sformatf("found=%0b index=%0d last=%0b",
                                              got.found, got.taken_index, got.last));
                end else begin
                    want = expected_results.pop_front();
                    if (got.found !== want.found || got.taken_index !== want.taken_index
                            || got.last !== want.last) begin
                        mismatches++;
                        $write("%0t: result mismatch expected found=%0b index=%0d last=%0b",
                               $time, want.found, want.taken_index, want.last);
                        $display(" actual found=%0b index=%0d last=%0b",
                                 got.found, got.taken_index, got.last);
                    end
                end
            end
            if (cfg_bus.valid && cfg_bus.ready && int'(cfg_bus.index) < NNODES)
                node_masks[cfg_bus.index] = cfg_bus.data;
            if (cmd_bus.valid && cmd_bus.ready) begin
                seen.command   = cmd_bus.command;
                seen.cpu_index = cmd_bus.cpu_index;
                seen.node_id   = cmd_bus.node_id;
                predict_allocation(seen);
            end
        end
    end

    // ------------------------------------------------------------------
    // command driver: bursts of random length separated by random gaps
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin : cmd_driver
        t_cpu_cmd c;
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
        end else if (!cmd_bus.valid || cmd_accepted) begin
            if (gap_left > 0) begin
                gap_left      <= gap_left - 1;
                cmd_bus.valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                c = pending_cmds.pop_front();
                cmd_bus.valid     <= 1'b1;
                cmd_bus.command   <= c.command;
                cmd_bus.cpu_index <= c.cpu_index;
                cmd_bus.node_id   <= c.node_id;
                if (burst_left <= 1) begin
                    // about a third of bursts run back to back with no gap
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                cmd_bus.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result receiver: rotating stall styles, plus one long hold-off on request
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (long_hold_armed && hold_count < LONG_HOLD_CYCLES) begin
            // block fills up and must stall its command input
            hold_count    <= hold_count + 1;
            rsp_bus.ready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                stall_style  <= $urandom_range(0, 3);
                pattern_left <= $urandom_range(16, 96);
            end else begin
                pattern_left <= pattern_left - 1;
            end
            rsp_toggle <= ~rsp_toggle;
            case (stall_style)
                0:       rsp_bus.ready <= 1'b1;                          // never stall
                1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);   // light stalls
                2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);   // heavy stalls
                default: rsp_bus.ready <= rsp_toggle;                    // alternating
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_cmd(input logic [CMD_W-1:0] command, input logic [IDX_W-1:0] cpu,
                            input logic [NODE_W-1:0] node);
        t_cpu_cmd c;
        c.command    = command;
        c.cpu_index  = cpu;
        c.node_id    = node;
        pending_cmds = {pending_cmds, c};
    endtask

    function automatic t_cpu_cmd random_command();
        t_cpu_cmd    c;
        int unsigned roll;
        roll        = $urandom_range(0, 99);
        // half the indices land in a small window so unidle hits set bits
        c.cpu_index = ($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, 7))
                                                  : IDX_W'($urandom);
        c.node_id   = NODE_W'($urandom);
        if (roll < 40)
            c.command = icba_pkg::CMD_MARK_IDLE;
        else if (roll < 52)
            c.command = icba_pkg::CMD_TAKE_ANY;
        else if (roll < 70)
            c.command = icba_pkg::CMD_TAKE_IN_NODE;
        else if (roll < 78)
            c.command = icba_pkg::CMD_TAKE_ALL;
        else if (roll < 95)
            c.command = icba_pkg::CMD_UNIDLE;
        else
            c.command = CMD_W'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));
        return c;
    endfunction

    // mostly fill-and-drain sequences with random content, the rest loose commands
    task automatic add_random_commands(input int unsigned n_items);
        int unsigned      added;
        int unsigned      k;
        logic [IDX_W-1:0] base;
        t_cpu_cmd         c;
        added = 0;
        while (added < n_items) begin
            if ($urandom_range(0, 9) < 4) begin
                k    = $urandom_range(1, 8);
                base = IDX_W'($urandom);
                repeat (k)
                    push_cmd(icba_pkg::CMD_MARK_IDLE, base + IDX_W'($urandom_range(0, 7)),
                             '0);
                case ($urandom_range(0, 2))
                    0: push_cmd(icba_pkg::CMD_TAKE_ALL, '0, '0);
                    1: repeat (2) push_cmd(icba_pkg::CMD_TAKE_IN_NODE, '0, NODE_W'($urandom));
                    default: repeat (2)
                        push_cmd(icba_pkg::CMD_UNIDLE, base + IDX_W'($urandom_range(0, 7)),
                                 '0);
                endcase
                added += k + 2;
            end else begin
                c = random_command();
                push_cmd(c.command, c.cpu_index, c.node_id);
                if (c.command <= icba_pkg::CMD_UNIDLE)
                    added++;
            end
        end
    endtask

    // config writes only happen with the block idle
    task automatic write_node_mask(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic load_node_masks(input logic [63:0] m0, input logic [63:0] m1,
                                   input logic [63:0] m2, input logic [63:0] m3);
        write_node_mask(NODE_MASK_ZERO, m0);
        write_node_mask(NODE_MASK_ONE, m1);
        write_node_mask(NODE_MASK_TWO, m2);
        write_node_mask(NODE_MASK_THREE, m3);
    endtask

    // all commands sent and every result back, then a drain wait for trailing marks
    task automatic wait_for_drain();
        while (pending_cmds.size() != 0 || cmd_bus.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [63:0] random_mask();
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n           = 1'b0;
        cmd_bus.valid     = 1'b0;
        cmd_bus.command   = icba_pkg::CMD_MARK_IDLE;
        cmd_bus.cpu_index = '0;
        cmd_bus.node_id   = '0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = NODE_MASK_ZERO;
        cfg_bus.data      = '0;
        rsp_bus.ready     = 1'b1;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full, empty, alternating and end-bit node masks
        load_node_masks({64{1'b1}}, 64'd0, 64'h5555_5555_5555_5555, 64'h8000_0000_0000_0001);
        push_cmd(icba_pkg::CMD_TAKE_ANY, '0, '0);       // empty map: not found
        push_cmd(icba_pkg::CMD_TAKE_ALL, '0, '0);       // empty map: single not-found beat
        push_cmd(icba_pkg::CMD_TAKE_IN_NODE, '0, 2'd0); // empty map under a full mask
        push_cmd(icba_pkg::CMD_UNIDLE, '0, '0);         // unidle of a clear bit
        push_cmd(icba_pkg::CMD_MARK_IDLE, '0, '0);
        push_cmd(icba_pkg::CMD_MARK_IDLE, 6'd63, '0);
        push_cmd(icba_pkg::CMD_MARK_IDLE, 6'd63, '0);   // already idle: no change
        push_cmd(icba_pkg::CMD_TAKE_IN_NODE, '0, 2'd1); // empty node mask
        push_cmd(icba_pkg::CMD_TAKE_IN_NODE, '0, 2'd3); // takes cpu 0
        push_cmd(icba_pkg::CMD_TAKE_IN_NODE, '0, 2'd3); // takes cpu 63
        push_cmd(icba_pkg::CMD_MARK_IDLE, 6'd5, '0);
        push_cmd(icba_pkg::CMD_MARK_IDLE, 6'd6, '0);
        push_cmd(icba_pkg::CMD_UNIDLE, 6'd5, '0);       // found
        push_cmd(icba_pkg::CMD_UNIDLE, 6'd5, '0);       // second time: not found
        push_cmd(CMD_RESERVED_FIRST, 6'd6, 2'd3);       // reserved codes are ignored
        push_cmd(CMD_RESERVED_MID, 6'd6, 2'd2);
        push_cmd(CMD_RESERVED_LAST, 6'd6, 2'd1);
        push_cmd(icba_pkg::CMD_TAKE_ANY, '0, '0);       // takes cpu 6
        push_cmd(icba_pkg::CMD_MARK_IDLE, 6'd63, '0);
        push_cmd(icba_pkg::CMD_MARK_IDLE, 6'd0, '0);
        push_cmd(icba_pkg::CMD_MARK_IDLE, 6'd42, '0);
        push_cmd(icba_pkg::CMD_MARK_IDLE, 6'd21, '0);
        push_cmd(icba_pkg::CMD_TAKE_ALL, '0, '0);       // 0, 21, 42, 63
        push_cmd(icba_pkg::CMD_MARK_IDLE, 6'd1, '0);
        push_cmd(icba_pkg::CMD_TAKE_IN_NODE, '0, 2'd2); // odd cpu outside even mask
        wait_for_drain();

        // random masks, mixed traffic
        load_node_masks(random_mask(), random_mask(), random_mask(), random_mask());
        add_random_commands(60);
        wait_for_drain();

        // swapped extremes; receiver holds off while every cpu is marked, so the take_all stalls
        load_node_masks(64'd0, {64{1'b1}}, random_mask(), 64'hAAAA_AAAA_AAAA_AAAA);
        @(posedge i_clk);
        long_hold_armed <= 1'b1;
        for (int i = 0; i < 64; i++)
            push_cmd(icba_pkg::CMD_MARK_IDLE, IDX_W'(i), '0);
        push_cmd(icba_pkg::CMD_TAKE_ALL, '0, '0);       // 64 beats
        add_random_commands(60);
        wait_for_drain();

        load_node_masks(random_mask(), random_mask(), random_mask(), random_mask());
        add_random_commands(60);
        wait_for_drain();

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #6_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
